>>> hw/rtl/afk_pkg.sv
// Shared types, constants and rounding helper for the four-joint kinematics pipeline
package afk_pkg;

    localparam int ANG_W   = 17;
    localparam int LEN_W   = 18;
    localparam int ROT_W   = 16;
    localparam int TRANS_W = 22;
    localparam int IDX_W   = 2;

    // Q30 sine/cosine, signed, magnitude up to 2^30
    localparam int Q_W  = 32;
    localparam int X_W  = 14;
    localparam int U_W  = 31;
    localparam int CW   = 36;
    localparam int PW   = 72;

    localparam int QS_ST   = 17;
    localparam int TRIG_ST = QS_ST + 2;
    localparam int STEP_ST = 2;
    localparam int N_ST    = TRIG_ST + 3 * STEP_ST + 1;

    localparam logic signed [17:0] FULL_TURN    = 18'sd36000;
    localparam logic [15:0]        QUARTER_16   = 16'd9000;
    localparam logic [15:0]        HALF_16      = 16'd18000;
    localparam logic [15:0]        THREEQ_16    = 16'd27000;
    localparam logic [X_W-1:0]     QUARTER_TURN = 14'd9000;

    // u = 119304*x + floor((5824*x + 4500) / 9000), exact form of x*2^30/9000 rounded
    localparam logic [31:0] U_BASE_MUL = 32'd119304;
    localparam logic [31:0] U_REM_MUL  = 32'd5824;
    localparam logic [31:0] U_REM_OFS  = 32'd4500;
    localparam logic [48:0] RECIP_9000 = 49'd7635497;
    localparam int          RECIP_SH   = 36;

    localparam logic signed [Q_W-1:0] QONE = 32'sd1073741824;

    localparam logic signed [31:0] SIN_COEF [0:5] = '{
        -32'sd3864, 32'sd172272, -32'sd5026994, 32'sd85569306,
        -32'sd693598669, 32'sd1686629713
    };

    localparam logic signed [PW-1:0] ROT_LIM   = 72'sd16384;
    localparam logic signed [PW-1:0] TRANS_LIM = 72'sd1048576;

    typedef enum logic [IDX_W-1:0] {
        REG_LINK1 = 2'd0,
        REG_LINK2 = 2'd1,
        REG_LINK3 = 2'd2,
        REG_LINK5 = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        QD_FIRST  = 2'd0,
        QD_SECOND = 2'd1,
        QD_THIRD  = 2'd2,
        QD_FOURTH = 2'd3
    } quad_t;

    typedef logic signed [Q_W-1:0] q30_t;
    typedef logic signed [CW-1:0]  ent_t;

    typedef struct packed {
        ent_t [2:0][2:0] r;
        ent_t [2:0]      t;
    } xf_t;

    // Shift right with rounding half away from zero
    function automatic logic signed [PW-1:0] rnd_shift(input logic signed [PW-1:0] v,
                                                       input int sh);
        logic [PW-1:0] m;
        logic [PW-1:0] half;
        half = PW'(1) << (sh - 1);
        m = v[PW-1] ? PW'(-v) : PW'(v);
        m = (m + half) >> sh;
        return v[PW-1] ? -$signed(m) : $signed(m);
    endfunction

endpackage

>>> hw/rtl/arm_forward_kinematics_4joint_core.sv
// Top level: four joint angles in, pose (rotation and translation) out
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  input    | in_valid / in_stall  | joint1_angle joint2_angle joint3_angle joint5_angle
//  output   | out_valid / out_stall| rot_00..rot_22 trans_x trans_y trans_z
//  config   | cfg_we               | cfg_index cfg_data
//
// One transaction per cycle is accepted while the output is not stalled.
// Depth is set by the angle stage (19 stages: reduction, the 17-stage quarter-wave
// sine and quadrant selection) plus three 2-stage matrix steps and the output rounding stage.
// Each stage holds while the next one is full and stalled; empty stages fill freely.
// Reset clears the valid bits and loads the default link lengths.
module arm_forward_kinematics_4joint_core (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic signed [afk_pkg::ANG_W-1:0] joint1_angle,
    input  logic signed [afk_pkg::ANG_W-1:0] joint2_angle,
    input  logic signed [afk_pkg::ANG_W-1:0] joint3_angle,
    input  logic signed [afk_pkg::ANG_W-1:0] joint5_angle,
    output logic out_valid,
    input  logic out_stall,
    output logic signed [afk_pkg::ROT_W-1:0] rot_00,
    output logic signed [afk_pkg::ROT_W-1:0] rot_01,
    output logic signed [afk_pkg::ROT_W-1:0] rot_02,
    output logic signed [afk_pkg::ROT_W-1:0] rot_10,
    output logic signed [afk_pkg::ROT_W-1:0] rot_11,
    output logic signed [afk_pkg::ROT_W-1:0] rot_12,
    output logic signed [afk_pkg::ROT_W-1:0] rot_20,
    output logic signed [afk_pkg::ROT_W-1:0] rot_21,
    output logic signed [afk_pkg::ROT_W-1:0] rot_22,
    output logic signed [afk_pkg::TRANS_W-1:0] trans_x,
    output logic signed [afk_pkg::TRANS_W-1:0] trans_y,
    output logic signed [afk_pkg::TRANS_W-1:0] trans_z,
    input  logic cfg_we,
    input  logic [afk_pkg::IDX_W-1:0] cfg_index,
    input  logic [afk_pkg::LEN_W-1:0] cfg_data
);
    import afk_pkg::*;

    localparam int S1 = TRIG_ST;
    localparam int S2 = TRIG_ST + STEP_ST;
    localparam int S3 = TRIG_ST + 2 * STEP_ST;
    localparam int SO = N_ST - 1;

    logic [LEN_W-1:0] link1_reg, link2_reg, link3_reg, link5_reg;
    logic [N_ST-1:0]  v_reg, v_next, en;

    q30_t s1, c1, s2, c2, s3, c3, s5, c5;
    q30_t s3_pl [S1:S2-1];
    q30_t c3_pl [S1:S2-1];
    q30_t s5_pl [S1:S3-1];
    q30_t c5_pl [S1:S3-1];
    xf_t  tb, x1, x2, x3;

    logic signed [PW-1:0] rr [0:8];
    logic signed [PW-1:0] tr [0:2];
    logic signed [ROT_W-1:0]   rot_reg [0:8];
    logic signed [ROT_W-1:0]   rot_next [0:8];
    logic signed [TRANS_W-1:0] trans_reg [0:2];
    logic signed [TRANS_W-1:0] trans_next [0:2];

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link1_reg <= 18'd33280;
            link2_reg <= 18'd32000;
            link3_reg <= 18'd32000;
            link5_reg <= 18'd33280;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_LINK1: link1_reg <= cfg_data;
                REG_LINK2: link2_reg <= cfg_data;
                REG_LINK3: link3_reg <= cfg_data;
                REG_LINK5: link5_reg <= cfg_data;
                default:   link1_reg <= link1_reg;
            endcase
        end
    end

    // stage enables: a stage advances when empty or when the one after advances
    always_comb
    begin
        en[SO] = !v_reg[SO] || !out_stall;
        for (int k = SO - 1; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
        v_next[0] = en[0] ? in_valid : v_reg[0];
        for (int k = 1; k < N_ST; k++)
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign in_stall  = !en[0];
    assign out_valid = v_reg[SO];

    afk_trig u_trig1 (
        .clk(clk), .en(en[TRIG_ST-1:0]), .angle(joint1_angle), .sin_val(s1), .cos_val(c1)
    );
    afk_trig u_trig2 (
        .clk(clk), .en(en[TRIG_ST-1:0]), .angle(joint2_angle), .sin_val(s2), .cos_val(c2)
    );
    afk_trig u_trig3 (
        .clk(clk), .en(en[TRIG_ST-1:0]), .angle(joint3_angle), .sin_val(s3), .cos_val(c3)
    );
    afk_trig u_trig5 (
        .clk(clk), .en(en[TRIG_ST-1:0]), .angle(joint5_angle), .sin_val(s5), .cos_val(c5)
    );

    // hold later joints until their step comes up
    always_ff @(posedge clk)
    begin
        if (en[S1])
        begin
            s3_pl[S1] <= s3;
            c3_pl[S1] <= c3;
            s5_pl[S1] <= s5;
            c5_pl[S1] <= c5;
        end
        for (int k = S1 + 1; k < S2; k++)
        begin
            if (en[k])
            begin
                s3_pl[k] <= s3_pl[k-1];
                c3_pl[k] <= c3_pl[k-1];
            end
        end
        for (int k = S1 + 1; k < S3; k++)
        begin
            if (en[k])
            begin
                s5_pl[k] <= s5_pl[k-1];
                c5_pl[k] <= c5_pl[k-1];
            end
        end
    end

    // base transform: rotation about z, z offset of minus link1
    always_comb
    begin
        tb.r[0][0] = CW'(c1);
        tb.r[0][1] = -CW'(s1);
        tb.r[0][2] = '0;
        tb.r[1][0] = CW'(s1);
        tb.r[1][1] = CW'(c1);
        tb.r[1][2] = '0;
        tb.r[2][0] = '0;
        tb.r[2][1] = '0;
        tb.r[2][2] = CW'(QONE);
        tb.t[0]    = '0;
        tb.t[1]    = '0;
        tb.t[2]    = -CW'({link1_reg, 8'b0});
    end

    afk_step u_step2 (
        .clk(clk), .en(en[S1 +: STEP_ST]), .pin(tb), .s(s2), .c(c2),
        .len(link2_reg), .pout(x1)
    );
    afk_step u_step3 (
        .clk(clk), .en(en[S2 +: STEP_ST]), .pin(x1), .s(s3_pl[S2-1]), .c(c3_pl[S2-1]),
        .len(link3_reg), .pout(x2)
    );
    afk_step u_step5 (
        .clk(clk), .en(en[S3 +: STEP_ST]), .pin(x2), .s(s5_pl[S3-1]), .c(c5_pl[S3-1]),
        .len(link5_reg), .pout(x3)
    );

    // round to output formats and saturate
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                rr[i*3+j] = rnd_shift(PW'($signed(x3.r[i][j])), 16);
                priority if (rr[i*3+j] > ROT_LIM)
                    rot_next[i*3+j] = ROT_LIM[ROT_W-1:0];
                else if (rr[i*3+j] < -ROT_LIM)
                    rot_next[i*3+j] = -ROT_LIM[ROT_W-1:0];
                else
                    rot_next[i*3+j] = rr[i*3+j][ROT_W-1:0];
            end
            tr[i] = rnd_shift(PW'($signed(x3.t[i])), 8);
            priority if (tr[i] > TRANS_LIM)
                trans_next[i] = TRANS_LIM[TRANS_W-1:0];
            else if (tr[i] < -TRANS_LIM)
                trans_next[i] = -TRANS_LIM[TRANS_W-1:0];
            else
                trans_next[i] = tr[i][TRANS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[SO])
        begin
            for (int k = 0; k < 9; k++)
                rot_reg[k] <= rot_next[k];
            for (int k = 0; k < 3; k++)
                trans_reg[k] <= trans_next[k];
        end
    end

    assign rot_00  = rot_reg[0];
    assign rot_01  = rot_reg[1];
    assign rot_02  = rot_reg[2];
    assign rot_10  = rot_reg[3];
    assign rot_11  = rot_reg[4];
    assign rot_12  = rot_reg[5];
    assign rot_20  = rot_reg[6];
    assign rot_21  = rot_reg[7];
    assign rot_22  = rot_reg[8];
    assign trans_x = trans_reg[0];
    assign trans_y = trans_reg[1];
    assign trans_z = trans_reg[2];

endmodule

>>> hw/rtl/afk_qsin.sv
// Pipelined quarter-wave sine: x in 0..9000 to Q30 via odd polynomial, Horner form
module afk_qsin (
    input  logic                       clk,
    input  logic [afk_pkg::QS_ST-1:0]  en,
    input  logic [afk_pkg::X_W-1:0]    x,
    output logic [afk_pkg::U_W-1:0]    y
);
    import afk_pkg::*;

    logic [25:0]     v_reg, v_next;
    logic [U_W-1:0]  base_reg, base_next;
    logic [25:0]     v2_reg;
    logic [U_W-1:0]  base2_reg;
    logic [12:0]     pe_reg, pe_next;
    logic [48:0]     recip_prod;
    logic [25:0]     rem;
    logic [U_W-1:0]  u_next;
    logic [61:0]     uu_reg, uu_next;
    logic [62:0]     uu_rnd;
    logic [U_W-1:0]  u2_next;
    logic [U_W-1:0]  u_pl  [3:15];
    logic [U_W-1:0]  u2_pl [5:13];
    logic signed [63:0] m_reg  [0:4];
    logic signed [63:0] m_next [0:4];
    logic signed [31:0] p_reg  [0:4];
    logic signed [31:0] p_next [0:4];
    logic signed [31:0] p_in   [0:4];
    logic signed [PW-1:0] m_rnd [0:4];
    logic signed [63:0] f_reg, f_next;
    logic signed [PW-1:0] f_rnd;
    logic [U_W-1:0]  y_reg, y_next;

    always_comb
    begin
        v_next     = 26'(32'(x) * U_REM_MUL + U_REM_OFS);
        base_next  = U_W'(32'(x) * U_BASE_MUL);
        recip_prod = 49'(v_reg) * RECIP_9000;
        pe_next    = recip_prod[RECIP_SH +: 13];
        rem        = v2_reg - 26'(26'(pe_reg) * 26'(QUARTER_TURN));
        u_next     = base2_reg + U_W'(pe_reg) + U_W'(rem >= 26'(QUARTER_TURN));
        uu_next    = 62'(u_pl[3]) * 62'(u_pl[3]);
        uu_rnd     = {1'b0, uu_reg} + (63'd1 << 29);
        u2_next    = uu_rnd[60:30];
        for (int k = 0; k < 5; k++)
        begin
            p_in[k]   = (k == 0) ? SIN_COEF[0] : p_reg[(k == 0) ? 0 : k - 1];
            m_next[k] = p_in[k] * $signed({1'b0, u2_pl[5 + 2 * k]});
            m_rnd[k]  = rnd_shift(PW'(m_reg[k]), 30);
            p_next[k] = SIN_COEF[k + 1] + m_rnd[k][31:0];
        end
        f_next = p_reg[4] * $signed({1'b0, u_pl[15]});
        f_rnd  = rnd_shift(PW'(f_reg), 30);
        // clamp to 0..1.0
        priority if (f_rnd < 0)
            y_next = '0;
        else if (f_rnd > PW'(QONE))
            y_next = U_W'(QONE);
        else
            y_next = f_rnd[U_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            v_reg    <= v_next;
            base_reg <= base_next;
        end
        if (en[1])
        begin
            pe_reg    <= pe_next;
            v2_reg    <= v_reg;
            base2_reg <= base_reg;
        end
        if (en[2])
            u_pl[3] <= u_next;
        if (en[3])
            uu_reg <= uu_next;
        if (en[4])
            u2_pl[5] <= u2_next;
        if (en[15])
            f_reg <= f_next;
        if (en[16])
            y_reg <= y_next;
    end

    for (genvar s = 4; s <= 15; s++)
    begin : g_u
        always_ff @(posedge clk)
        begin
            if (en[s-1])
                u_pl[s] <= u_pl[s-1];
        end
    end

    for (genvar s = 6; s <= 13; s++)
    begin : g_u2
        always_ff @(posedge clk)
        begin
            if (en[s-1])
                u2_pl[s] <= u2_pl[s-1];
        end
    end

    for (genvar k = 0; k < 5; k++)
    begin : g_horner
        always_ff @(posedge clk)
        begin
            if (en[5 + 2 * k])
                m_reg[k] <= m_next[k];
            if (en[6 + 2 * k])
                p_reg[k] <= p_next[k];
        end
    end

    assign y = y_reg;

endmodule

>>> hw/rtl/afk_trig.sv
// Joint angle to Q30 sine and cosine of the negated angle
module afk_trig (
    input  logic                         clk,
    input  logic [afk_pkg::TRIG_ST-1:0]  en,
    input  logic signed [afk_pkg::ANG_W-1:0] angle,
    output afk_pkg::q30_t                sin_val,
    output afk_pkg::q30_t                cos_val
);
    import afk_pkg::*;

    logic signed [17:0] n0, n1, n2, r;
    logic [15:0]        ru;
    quad_t              q_next;
    logic [15:0]        xw;
    logic [X_W-1:0]     xa_reg, xb_reg;
    quad_t              q_pl [0:QS_ST];
    logic [U_W-1:0]     ya, yb;
    q30_t               pa, pb;
    q30_t               s_reg, s_next, c_reg, c_next;

    always_comb
    begin
        // theta = -angle, wrapped into one turn
        n0 = -(18'(angle));
        n1 = (n0 < 0) ? n0 + FULL_TURN : n0;
        n2 = (n1 < 0) ? n1 + FULL_TURN : n1;
        r  = (n2 >= FULL_TURN) ? n2 - FULL_TURN : n2;
        ru = r[15:0];
        priority if (ru < QUARTER_16)
        begin
            q_next = QD_FIRST;
            xw     = ru;
        end
        else if (ru < HALF_16)
        begin
            q_next = QD_SECOND;
            xw     = ru - QUARTER_16;
        end
        else if (ru < THREEQ_16)
        begin
            q_next = QD_THIRD;
            xw     = ru - HALF_16;
        end
        else
        begin
            q_next = QD_FOURTH;
            xw     = ru - THREEQ_16;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            q_pl[0] <= q_next;
            xa_reg  <= xw[X_W-1:0];
            xb_reg  <= QUARTER_TURN - xw[X_W-1:0];
        end
    end

    for (genvar s = 1; s <= QS_ST; s++)
    begin : g_q
        always_ff @(posedge clk)
        begin
            if (en[s])
                q_pl[s] <= q_pl[s-1];
        end
    end

    afk_qsin u_qsin_a (
        .clk (clk),
        .en  (en[QS_ST:1]),
        .x   (xa_reg),
        .y   (ya)
    );

    afk_qsin u_qsin_b (
        .clk (clk),
        .en  (en[QS_ST:1]),
        .x   (xb_reg),
        .y   (yb)
    );

    always_comb
    begin
        pa = q30_t'({1'b0, ya});
        pb = q30_t'({1'b0, yb});
        unique case (q_pl[QS_ST])
            QD_FIRST:
            begin
                s_next = pa;
                c_next = pb;
            end
            QD_SECOND:
            begin
                s_next = pb;
                c_next = -pa;
            end
            QD_THIRD:
            begin
                s_next = -pa;
                c_next = -pb;
            end
            QD_FOURTH:
            begin
                s_next = -pb;
                c_next = pa;
            end
            default:
            begin
                s_next = pa;
                c_next = pb;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[QS_ST+1])
        begin
            s_reg <= s_next;
            c_reg <= c_next;
        end
    end

    assign sin_val = s_reg;
    assign cos_val = c_reg;

endmodule

>>> hw/rtl/afk_step.sv
// One chain step: rotation about y with z offset applied on the left of a transform
module afk_step (
    input  logic                      clk,
    input  logic [afk_pkg::STEP_ST-1:0] en,
    input  afk_pkg::xf_t              pin,
    input  afk_pkg::q30_t             s,
    input  afk_pkg::q30_t             c,
    input  logic [afk_pkg::LEN_W-1:0] len,
    output afk_pkg::xf_t              pout
);
    import afk_pkg::*;

    logic signed [CW-1:0] p0 [0:3];
    logic signed [CW-1:0] p2 [0:3];
    logic signed [67:0] a0_reg [0:3];
    logic signed [67:0] b0_reg [0:3];
    logic signed [67:0] a2_reg [0:3];
    logic signed [67:0] b2_reg [0:3];
    logic signed [67:0] a0_next [0:3];
    logic signed [67:0] b0_next [0:3];
    logic signed [67:0] a2_next [0:3];
    logic signed [67:0] b2_next [0:3];
    ent_t [2:0] row1_reg;
    ent_t       t1_reg;
    logic signed [PW-1:0] r0 [0:3];
    logic signed [PW-1:0] r2 [0:3];
    xf_t  out_reg, out_next;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            p0[j] = (j < 3) ? $signed(pin.r[0][(j < 3) ? j : 0]) : $signed(pin.t[0]);
            p2[j] = (j < 3) ? $signed(pin.r[2][(j < 3) ? j : 0]) : $signed(pin.t[2]);
            a0_next[j] = c * p0[j];
            b0_next[j] = s * p2[j];
            a2_next[j] = c * p2[j];
            b2_next[j] = s * p0[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int j = 0; j < 4; j++)
            begin
                a0_reg[j] <= a0_next[j];
                b0_reg[j] <= b0_next[j];
                a2_reg[j] <= a2_next[j];
                b2_reg[j] <= b2_next[j];
            end
            row1_reg <= pin.r[1];
            t1_reg   <= pin.t[1];
        end
    end

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            r0[j] = rnd_shift(PW'(69'(a0_reg[j]) + 69'(b0_reg[j])), 30);
            r2[j] = rnd_shift(PW'(69'(a2_reg[j]) - 69'(b2_reg[j])), 30);
        end
        for (int j = 0; j < 3; j++)
        begin
            out_next.r[0][j] = r0[j][CW-1:0];
            out_next.r[2][j] = r2[j][CW-1:0];
        end
        out_next.r[1] = row1_reg;
        out_next.t[0] = r0[3][CW-1:0];
        out_next.t[1] = t1_reg;
        out_next.t[2] = r2[3][CW-1:0] - CW'({len, 8'b0});
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
            out_reg <= out_next;
    end

    assign pout = out_reg;

endmodule
